// File: rtl/shuttle_speed_zone_controller_assert.svh
// ----------------------------------------------------------------------------
// shuttle speed zone controller assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SHUTTLE_SPEED_ZONE_CONTROLLER_ASSERT_SVH
`define SHUTTLE_SPEED_ZONE_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SSZC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sszc check failed");

// next-cycle implication
`define SSZC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sszc check failed");

`else

`define SSZC_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SSZC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/sszc_pkg.sv
// ----------------------------------------------------------------------------
// sszc_pkg
// types and constants shared by the shuttle speed zone controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sszc_pkg;

   typedef enum logic [2:0] {
      CSR_STOP_ZONE   = 3'd0,
      CSR_CREEP_ZONE  = 3'd1,
      CSR_BRAKE_ZONE  = 3'd2,
      CSR_TOP_LEVEL   = 3'd3,
      CSR_CRAWL_LEVEL = 3'd4,
      CSR_LEVEL_STEP  = 3'd5,
      CSR_HOLD_TOP    = 3'd6
   } csr_index_type;

   localparam logic [9:0]  BAD_LIMIT   = 10'd2;
   localparam logic [9:0]  RANGE_CAP   = 10'd100;
   localparam logic [9:0]  RANGE_CLAMP = 10'd101;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

   localparam logic [1:0]  LAMP_OFF    = 2'd0;
   localparam logic [1:0]  LAMP_GREEN  = 2'd1;
   localparam logic [1:0]  LAMP_RED    = 2'd2;

   localparam logic [9:0]  RST_STOP_ZONE   = 10'd10;
   localparam logic [9:0]  RST_CREEP_ZONE  = 10'd20;
   localparam logic [9:0]  RST_BRAKE_ZONE  = 10'd40;
   localparam logic [9:0]  RST_TOP_LEVEL   = 10'd1023;
   localparam logic [9:0]  RST_CRAWL_LEVEL = 10'd300;
   localparam logic [9:0]  RST_LEVEL_STEP  = 10'd50;

   typedef struct packed {
      logic [9:0] stop_zone;
      logic [9:0] creep_zone;
      logic [9:0] brake_zone;
      logic [9:0] top_level;
      logic [9:0] crawl_level;
      logic [9:0] level_step;
      logic       hold_top;
   } cfg_type;

   typedef struct packed {
      logic [9:0]  drive_level;
      logic        heading;
      logic [1:0]  lamp;
      logic [15:0] bad_count;
      logic [15:0] bad_run;
      logic [15:0] good_count;
   } state_type;

   typedef struct packed {
      logic reversed;
      logic ok;
   } flags_type;

endpackage

// File: rtl/shuttle_speed_zone_controller.sv
// ----------------------------------------------------------------------------
// shuttle_speed_zone_controller
// range-driven drive level, heading and lamp control for a station shuttle
// ----------------------------------------------------------------------------
// Takes one range reading per item and returns one result item per reading.
// The block accepts an item every clock cycle while the receiver does not
// stall. Each item passes through the input register and then the result
// register, which presents it to the receiver. The drive state is updated
// in the same cycle a reading moves from the input register to the result
// register, which is what keeps the rate at one item per cycle while the
// receiver does not stall. Configuration registers are written through the
// csr port and must only change while no reading is in flight.
`timescale 1ns / 1ps

`include "shuttle_speed_zone_controller_assert.svh"

module shuttle_speed_zone_controller (
   input  logic        clock,
   input  logic        reset,
   // reading channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [9:0]  req_range_cm,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_drive_duty,
   output logic        rsp_heading_right,
   output logic [1:0]  rsp_lamp_code,
   output logic        rsp_reversed_now,
   output logic        rsp_read_ok,
   output logic [15:0] rsp_bad_total,
   output logic [15:0] rsp_bad_streak,
   output logic [15:0] rsp_good_total,
   // configuration write port
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   // configuration registers
   sszc_pkg::cfg_type   cfg_ff, cfg_in;

   // input stage
   logic                in_valid_ff;
   logic [9:0]          in_range_ff;

   // shuttle state; it only changes when a result is loaded, so it doubles
   // as the state part of the result register
   sszc_pkg::state_type state_ff, state_in;

   // result flags
   logic                out_valid_ff, out_valid_in;
   sszc_pkg::flags_type flags_ff, flags_in;

   logic                out_free;
   logic                advance;
   logic                take_req;

   // result register can load when empty or being drained this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   // input register can load when empty or moving forward this cycle
   assign req_stall = in_valid_ff && !out_free;
   assign take_req  = req_valid && !req_stall;

   sszc_step u_step (
      .cfg      (cfg_ff),
      .cur      (state_ff),
      .range_cm (in_range_ff),
      .nxt      (state_in),
      .flags    (flags_in)
   );

   // config write decode, unknown index ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (sszc_pkg::csr_index_type'(csr_index))
            sszc_pkg::CSR_STOP_ZONE:   cfg_in.stop_zone   = csr_wdata;
            sszc_pkg::CSR_CREEP_ZONE:  cfg_in.creep_zone  = csr_wdata;
            sszc_pkg::CSR_BRAKE_ZONE:  cfg_in.brake_zone  = csr_wdata;
            sszc_pkg::CSR_TOP_LEVEL:   cfg_in.top_level   = csr_wdata;
            sszc_pkg::CSR_CRAWL_LEVEL: cfg_in.crawl_level = csr_wdata;
            sszc_pkg::CSR_LEVEL_STEP:  cfg_in.level_step  = csr_wdata;
            sszc_pkg::CSR_HOLD_TOP:    cfg_in.hold_top    = csr_wdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_zone   <= sszc_pkg::RST_STOP_ZONE;
         cfg_ff.creep_zone  <= sszc_pkg::RST_CREEP_ZONE;
         cfg_ff.brake_zone  <= sszc_pkg::RST_BRAKE_ZONE;
         cfg_ff.top_level   <= sszc_pkg::RST_TOP_LEVEL;
         cfg_ff.crawl_level <= sszc_pkg::RST_CRAWL_LEVEL;
         cfg_ff.level_step  <= sszc_pkg::RST_LEVEL_STEP;
         cfg_ff.hold_top    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take_req || advance) begin
         in_valid_ff <= take_req;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_range_ff <= req_range_cm;
      end
   end

   // shuttle state, heading left, lamps off, counters clear after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.drive_level <= 10'd0;
         state_ff.heading     <= 1'b0;
         state_ff.lamp        <= sszc_pkg::LAMP_OFF;
         state_ff.bad_count   <= 16'd0;
         state_ff.bad_run     <= 16'd0;
         state_ff.good_count  <= 16'd0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result valid: loads on advance, clears when drained with nothing behind
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flags_ff <= flags_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_drive_duty    = state_ff.drive_level;
   assign rsp_heading_right = state_ff.heading;
   assign rsp_lamp_code     = state_ff.lamp;
   assign rsp_reversed_now  = flags_ff.reversed;
   assign rsp_read_ok       = flags_ff.ok;
   assign rsp_bad_total     = state_ff.bad_count;
   assign rsp_bad_streak    = state_ff.bad_run;
   assign rsp_good_total    = state_ff.good_count;

   // a reversal always leaves the drive stopped
   `SSZC_ASSERT_NOW(a_rev_stops, clock, reset, rsp_valid && rsp_reversed_now, rsp_drive_duty == 10'd0 && rsp_read_ok)
   // a reversal flips the heading relative to the previous state
   `SSZC_ASSERT_NEXT(a_rev_flips, clock, reset, advance && flags_in.reversed, state_ff.heading != $past(state_ff.heading))
   // the input side only stalls while holding an item that cannot move on
   `SSZC_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, in_valid_ff && out_valid_ff && rsp_stall)
   // the lamp never shows the unused code
   `SSZC_ASSERT_NOW(a_lamp_code, clock, reset, rsp_valid, rsp_lamp_code <= sszc_pkg::LAMP_RED)

endmodule

// File: rtl/sszc_step.sv
// ----------------------------------------------------------------------------
// sszc_step
// next-state logic for one range reading
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sszc_step (
   input  sszc_pkg::cfg_type   cfg,
   input  sszc_pkg::state_type cur,
   input  logic [9:0]          range_cm,
   output sszc_pkg::state_type nxt,
   output sszc_pkg::flags_type flags
);

   logic [9:0]  range_clamped;
   logic [10:0] floor_sum;
   logic [10:0] up_sum;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      sat_inc = (v == sszc_pkg::COUNT_MAX) ? v : v + 16'd1;
   endfunction

   assign range_clamped = (range_cm > sszc_pkg::RANGE_CAP) ? sszc_pkg::RANGE_CLAMP : range_cm;
   // level - step < crawl  <=>  level < crawl + step
   assign floor_sum = {1'b0, cfg.crawl_level} + {1'b0, cfg.level_step};
   assign up_sum    = {1'b0, cur.drive_level} + {1'b0, cfg.level_step};

   always_comb begin
      nxt            = cur;
      flags.reversed = 1'b0;
      flags.ok       = 1'b0;
      if (range_cm < sszc_pkg::BAD_LIMIT) begin
         nxt.bad_count = sat_inc(cur.bad_count);
         nxt.bad_run   = sat_inc(cur.bad_run);
      end else begin
         flags.ok       = 1'b1;
         nxt.bad_run    = 16'd0;
         nxt.good_count = sat_inc(cur.good_count);
         if (range_clamped < cfg.stop_zone) begin
            nxt.drive_level = 10'd0;
            nxt.heading     = ~cur.heading;
            nxt.lamp        = cur.heading ? sszc_pkg::LAMP_RED : sszc_pkg::LAMP_GREEN;
            flags.reversed  = 1'b1;
         end else if (range_clamped < cfg.creep_zone) begin
            if (!cfg.hold_top) begin
               nxt.drive_level = cfg.crawl_level;
            end
         end else if (range_clamped < cfg.brake_zone) begin
            if (cfg.hold_top) begin
               nxt.drive_level = cfg.top_level;
            end else if ({1'b0, cur.drive_level} < floor_sum) begin
               nxt.drive_level = cfg.crawl_level;
            end else begin
               nxt.drive_level = cur.drive_level - cfg.level_step;
            end
         end else begin
            if (cfg.hold_top) begin
               nxt.drive_level = cfg.top_level;
            end else if (up_sum > {1'b0, cfg.top_level}) begin
               nxt.drive_level = cfg.top_level;
            end else begin
               nxt.drive_level = up_sum[9:0];
            end
         end
      end
   end

endmodule

// File: sim/tb_shuttle_speed_zone_controller.sv
// ----------------------------------------------------------------------------
// tb_shuttle_speed_zone_controller
// self-checking bench for the shuttle speed zone controller
// ----------------------------------------------------------------------------
// A shadow model of the drive state predicts every result at the moment its
// range reading is accepted. A monitor compares each returned item field by
// field against the oldest prediction. Directed tests cover the zone borders,
// the clamp above 100, bad readings and odd register settings. Random phases
// under random register settings and random idling on both sides follow, then
// a long receiver hold-off that backs up the input.
`timescale 1ns / 1ps

module tb_shuttle_speed_zone_controller;

   // timing of the bench
   localparam int CLOCK_HALF      = 2;
   localparam int RESET_CYCLES    = 6;
   localparam int RESULT_LATENCY  = 2;
   localparam int DRAIN_SLACK     = 4 * RESULT_LATENCY;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int MAX_REPORTS     = 40;

   // random part of the run
   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_ITEMS     = 250;

   // an index outside the register map; writes to it must be ignored
   localparam logic [2:0] CSR_UNUSED_INDEX = 3'd7;

   // one result item as the block returns it
   typedef struct packed {
      logic [9:0]  drive_duty;
      logic        heading_right;
      logic [1:0]  lamp_code;
      logic        reversed_now;
      logic        read_ok;
      logic [15:0] bad_total;
      logic [15:0] bad_streak;
      logic [15:0] good_total;
   } drive_result_type;

   // ports; the inputs driven by the bench are known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [9:0]  req_range_cm = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [9:0]  rsp_drive_duty;
   logic        rsp_heading_right;
   logic [1:0]  rsp_lamp_code;
   logic        rsp_reversed_now;
   logic        rsp_read_ok;
   logic [15:0] rsp_bad_total;
   logic [15:0] rsp_bad_streak;
   logic [15:0] rsp_good_total;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [9:0]  csr_wdata = '0;

   // shadow copy of the registers and the drive state
   sszc_pkg::cfg_type   shadow_cfg;
   sszc_pkg::state_type shadow_state;

   // predictions waiting for their result item
   drive_result_type pending_results[$];

   // idling controls, set by the test sequence
   bit sender_idle   = 1'b0;
   bit receiver_idle = 1'b0;
   int hold_requests = 0;

   // bookkeeping
   int fail_count    = 0;
   int report_count  = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int stops_seen    = 0;
   int bad_seen      = 0;
   int config_sets   = 0;
   int cycle_count   = 0;

   shuttle_speed_zone_controller uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_range_cm      (req_range_cm),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive_duty    (rsp_drive_duty),
      .rsp_heading_right (rsp_heading_right),
      .rsp_lamp_code     (rsp_lamp_code),
      .rsp_reversed_now  (rsp_reversed_now),
      .rsp_read_ok       (rsp_read_ok),
      .rsp_bad_total     (rsp_bad_total),
      .rsp_bad_streak    (rsp_bad_streak),
      .rsp_good_total    (rsp_good_total),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 4 ns clock
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time,
                  pending_results.size());
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // shadow model
   // ------------------------------------------------------------------------

   function automatic logic [15:0] sat_bump(input logic [15:0] count);
      return (count == sszc_pkg::COUNT_MAX) ? count : count + 16'd1;
   endfunction

   // advance the shadow state by one reading and return the result it causes
   function automatic drive_result_type step_shadow(input logic [9:0] range_in);
      drive_result_type res;
      logic [9:0]       range_eff;
      int               level;
      res = '0;
      range_eff = range_in;
      if (range_in < sszc_pkg::BAD_LIMIT) begin
         // bad reading: counters only, drive left alone
         shadow_state.bad_count = sat_bump(shadow_state.bad_count);
         shadow_state.bad_run   = sat_bump(shadow_state.bad_run);
      end else begin
         res.read_ok = 1'b1;
         shadow_state.bad_run    = '0;
         shadow_state.good_count = sat_bump(shadow_state.good_count);
         if (range_eff > sszc_pkg::RANGE_CAP)
            range_eff = sszc_pkg::RANGE_CLAMP;
         // zones are tested in order, whatever the register values are
         if (range_eff < shadow_cfg.stop_zone) begin
            shadow_state.drive_level = '0;
            shadow_state.heading     = ~shadow_state.heading;
            shadow_state.lamp = shadow_state.heading ? sszc_pkg::LAMP_GREEN
                                                     : sszc_pkg::LAMP_RED;
            res.reversed_now = 1'b1;
         end else if (range_eff < shadow_cfg.creep_zone) begin
            if (!shadow_cfg.hold_top)
               shadow_state.drive_level = shadow_cfg.crawl_level;
         end else if (range_eff < shadow_cfg.brake_zone) begin
            if (shadow_cfg.hold_top) begin
               shadow_state.drive_level = shadow_cfg.top_level;
            end else begin
               // floor at crawl level, even when that lies above the old level
               level = int'(shadow_state.drive_level) - int'(shadow_cfg.level_step);
               if (level < int'(shadow_cfg.crawl_level))
                  level = int'(shadow_cfg.crawl_level);
               shadow_state.drive_level = level[9:0];
            end
         end else begin
            if (shadow_cfg.hold_top) begin
               shadow_state.drive_level = shadow_cfg.top_level;
            end else begin
               level = int'(shadow_state.drive_level) + int'(shadow_cfg.level_step);
               if (level > int'(shadow_cfg.top_level))
                  level = int'(shadow_cfg.top_level);
               shadow_state.drive_level = level[9:0];
            end
         end
      end
      res.drive_duty    = shadow_state.drive_level;
      res.heading_right = shadow_state.heading;
      res.lamp_code     = shadow_state.lamp;
      res.bad_total     = shadow_state.bad_count;
      res.bad_streak    = shadow_state.bad_run;
      res.good_total    = shadow_state.good_count;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // receiver side: stall generator and result monitor
   // ------------------------------------------------------------------------

   // random stalls, plus a long hold-off each time one is requested
   always @(posedge clock) begin : rsp_stall_gen
      int stall_left;
      int hold_left;
      int hold_served;
      int pick;
      if (reset) begin
         stall_left  = 0;
         hold_left   = 0;
         hold_served = 0;
         rsp_stall  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_requests) begin
         // long hold-off, counted here so the sender keeps pushing meanwhile
         hold_served = hold_served + 1;
         hold_left   = HOLD_OFF_CYCLES - 1;
         rsp_stall  <= 1'b1;
      end else if (receiver_idle) begin
         if (stall_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick >= 95)
               stall_left = $urandom_range(10, 30);
            else if (pick >= 70)
               stall_left = $urandom_range(1, 3);
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want !== got) begin
         fail_count = fail_count + 1;
         if (report_count < MAX_REPORTS)
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time,
                     name, want, got);
         report_count = report_count + 1;
      end
   endtask

   // compare every accepted result item with the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      drive_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            fail_count = fail_count + 1;
            if (report_count < MAX_REPORTS)
               $display("%0t result item with no prediction waiting, duty %0d",
                        $time, rsp_drive_duty);
            report_count = report_count + 1;
         end else begin
            want = pending_results.pop_front();
            results_seen = results_seen + 1;
            check_field("drive_duty",    want.drive_duty,    rsp_drive_duty);
            check_field("heading_right", want.heading_right, rsp_heading_right);
            check_field("lamp_code",     want.lamp_code,     rsp_lamp_code);
            check_field("reversed_now",  want.reversed_now,  rsp_reversed_now);
            check_field("read_ok",       want.read_ok,       rsp_read_ok);
            check_field("bad_total",     want.bad_total,     rsp_bad_total);
            check_field("bad_streak",    want.bad_streak,    rsp_bad_streak);
            check_field("good_total",    want.good_total,    rsp_good_total);
         end
      end
   end

   // ------------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------------

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      else if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one reading, predict its result once accepted
   task automatic send_reading(input logic [9:0] range_in);
      drive_result_type predicted;
      int               gap;
      req_valid    <= 1'b1;
      req_range_cm <= range_in;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      predicted = step_shadow(range_in);
      pending_results.push_back(predicted);
      items_sent = items_sent + 1;
      if (predicted.reversed_now)
         stops_seen = stops_seen + 1;
      if (!predicted.read_ok)
         bad_seen = bad_seen + 1;
      gap = sender_idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and wait for every predicted item to come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [9:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // write every register, only ever called with the block idle
   task automatic apply_cfg(input sszc_pkg::cfg_type c);
      logic [9:0] hold_word;
      hold_word    = 10'($urandom_range(0, 1023));
      hold_word[0] = c.hold_top;
      write_csr(sszc_pkg::CSR_STOP_ZONE,   c.stop_zone);
      write_csr(sszc_pkg::CSR_CREEP_ZONE,  c.creep_zone);
      write_csr(sszc_pkg::CSR_BRAKE_ZONE,  c.brake_zone);
      write_csr(sszc_pkg::CSR_TOP_LEVEL,   c.top_level);
      write_csr(sszc_pkg::CSR_CRAWL_LEVEL, c.crawl_level);
      write_csr(sszc_pkg::CSR_LEVEL_STEP,  c.level_step);
      write_csr(sszc_pkg::CSR_HOLD_TOP,    hold_word);
      csr_wr_en  <= 1'b0;
      shadow_cfg  = c;
      config_sets = config_sets + 1;
   endtask

   function automatic sszc_pkg::cfg_type reset_cfg();
      sszc_pkg::cfg_type c;
      c.stop_zone   = sszc_pkg::RST_STOP_ZONE;
      c.creep_zone  = sszc_pkg::RST_CREEP_ZONE;
      c.brake_zone  = sszc_pkg::RST_BRAKE_ZONE;
      c.top_level   = sszc_pkg::RST_TOP_LEVEL;
      c.crawl_level = sszc_pkg::RST_CRAWL_LEVEL;
      c.level_step  = sszc_pkg::RST_LEVEL_STEP;
      c.hold_top    = 1'b0;
      return c;
   endfunction

   // a 10-bit register value: an extreme now and then, else full range
   function automatic logic [9:0] pick_level();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12)
         return 10'd0;
      else if (pick < 24)
         return 10'd1023;
      return 10'($urandom_range(0, 1023));
   endfunction

   // zone limits that matter sit near the clamped range, mostly in order
   function automatic logic [9:0] pick_zone();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         return 10'd0;
      else if (pick < 16)
         return 10'd1023;
      else if (pick < 24)
         return 10'($urandom_range(0, 1023));
      return 10'($urandom_range(0, 110));
   endfunction

   function automatic sszc_pkg::cfg_type random_cfg();
      sszc_pkg::cfg_type c;
      logic [9:0]        a, b, t;
      c.stop_zone  = pick_zone();
      c.creep_zone = pick_zone();
      c.brake_zone = pick_zone();
      if ($urandom_range(0, 99) < 70) begin
         // sort so every zone gets a band of its own
         a = c.stop_zone; b = c.creep_zone; t = c.brake_zone;
         if (a > b) begin a = c.creep_zone; b = c.stop_zone; end
         if (b > t) begin t = b; b = c.brake_zone; end
         if (a > b) begin c.stop_zone = b; b = a; a = c.stop_zone; end
         c.stop_zone = a; c.creep_zone = b; c.brake_zone = t;
      end
      c.top_level   = pick_level();
      c.crawl_level = pick_level();
      c.level_step  = pick_level();
      c.hold_top    = ($urandom_range(0, 99) < 25);
      return c;
   endfunction

   // readings weighted toward the zone bands, with bad ones mixed in
   function automatic logic [9:0] pick_range();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         return 10'($urandom_range(0, 1));
      else if (pick < 70)
         return 10'($urandom_range(2, 110));
      return 10'($urandom_range(0, 1023));
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // zone borders and bad readings under the reset register values
   task automatic test_zone_borders();
      send_reading(10'd0);     // bad, streak starts
      send_reading(10'd1);     // bad, streak grows
      send_reading(10'd1023);  // clamped, cruise ramp from zero
      send_reading(10'd101);
      send_reading(10'd100);
      send_reading(10'd2);     // lowest good reading, stop turns right
      send_reading(10'd9);     // stop again, turns left
      send_reading(10'd10);    // creep
      send_reading(10'd19);
      send_reading(10'd20);    // brake floors at crawl level
      send_reading(10'd39);
      send_reading(10'd40);    // cruise
      send_reading(10'd1);     // bad reading holds the drive
      send_reading(10'd512);
      wait_drained();
   endtask

   // extreme and odd register settings, and a write to an unknown index
   task automatic test_odd_settings();
      sszc_pkg::cfg_type c;
      c = '0;
      apply_cfg(c);                          // every register at zero
      send_reading(10'd2);
      send_reading(10'd1023);
      wait_drained();
      c = '1;                                // every register at its top
      apply_cfg(c);
      send_reading(10'd1023);                // clamp keeps it in stop zone
      send_reading(10'd50);
      wait_drained();
      c = reset_cfg();
      c.hold_top = 1'b1;                     // ramps pinned at top level
      c.top_level = 10'd700;
      apply_cfg(c);
      send_reading(10'd15);                  // creep leaves level alone
      send_reading(10'd30);
      send_reading(10'd15);
      send_reading(10'd80);
      wait_drained();
      c.hold_top    = 1'b0;                  // crawl above top, huge step
      c.top_level   = 10'd100;
      c.crawl_level = 10'd900;
      c.level_step  = 10'd1023;
      apply_cfg(c);
      write_csr(CSR_UNUSED_INDEX, 10'h3FF);  // must not disturb anything
      csr_wr_en <= 1'b0;
      send_reading(10'd30);
      send_reading(10'd90);
      send_reading(10'd30);
      send_reading(10'd12);
      wait_drained();
   endtask

   // random phases with fresh registers and a fresh idling mix each time
   task automatic test_random_phases();
      int burst;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_cfg(random_cfg());
         sender_idle   = (phase % 4 == 0) || (phase % 4 == 1);
         receiver_idle = (phase % 4 == 0) || (phase % 4 == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 3) begin
               // a run of bad readings to grow the streak
               burst = $urandom_range(2, 12);
               repeat (burst) send_reading(10'($urandom_range(0, 1)));
               n = n + burst - 1;
            end else begin
               send_reading(pick_range());
            end
         end
         wait_drained();
      end
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
   endtask

   // receiver holds off while readings keep coming, input backs up
   task automatic test_backpressure();
      apply_cfg(reset_cfg());
      hold_requests = hold_requests + 1;
      repeat (40) send_reading(pick_range());
      wait_drained();
   endtask

   initial begin
      shadow_cfg   = reset_cfg();
      shadow_state = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_zone_borders();
      test_odd_settings();
      test_random_phases();
      test_backpressure();

      $display("%0d readings sent, %0d results checked under %0d register sets",
               items_sent, results_seen, config_sets);
      $display("%0d reversals and %0d bad readings predicted, %0d field errors",
               stops_seen, bad_seen, fail_count);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: shuttle_speed_zone_controller.f
+incdir+rtl
rtl/sszc_pkg.sv
rtl/sszc_step.sv
rtl/shuttle_speed_zone_controller.sv
sim/tb_shuttle_speed_zone_controller.sv
